// ===== hw/rtl/bitmap_block_allocator_macros.svh =====
// Assertion macros for the bitmap block allocator.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

`ifndef SYNTH
// Antecedent implies consequent in the same cycle.
`define BBA_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Condition never holds.
`define BBA_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed");
`else
`define BBA_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define BBA_ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

// ===== hw/rtl/bba_pkg.sv =====
// Shared constants and types for the bitmap block allocator.
// No dependencies; used by bba_search and bitmap_block_allocator.
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

   localparam int MAX_BLOCKS = 8192;
   localparam int CNT_W      = 14;
   localparam int WORD_BITS  = 32;
   localparam int BIT_AW     = $clog2(WORD_BITS);
   localparam int MAP_WORDS  = MAX_BLOCKS / WORD_BITS;
   localparam int WORD_AW    = $clog2(MAP_WORDS);
   localparam int IDX_W      = WORD_AW + BIT_AW;
   localparam int GROUP_SIZE = 16;
   localparam int GROUP_AW   = $clog2(GROUP_SIZE);
   localparam int GROUPS     = MAP_WORDS / GROUP_SIZE;
   localparam int GSEL_AW    = $clog2(GROUPS);

   localparam logic       CMD_ALLOC       = 1'b0;
   localparam logic       CMD_FREE        = 1'b1;
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_FREE  = 2'd1;
   localparam logic [1:0] STATUS_BAD_BLOCK = 2'd2;

   typedef struct packed {
      logic               found;
      logic [WORD_AW-1:0] word;
   } search_result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/bitmap_block_allocator.sv =====
// An allocate passes through the search, map read and modify states; a free goes straight
// to the map read. One item at a time: a new request is taken only when idle, and the
// modify state waits while the output is stalled; the map read is registered.
// Reset clears the per-word valid and full flags at once, so the map reads as all free
// with no clearing pass; the used count clears and block_count returns to 8192.
// Depends on bba_pkg, bba_search and bitmap_block_allocator_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_block_allocator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output wire logic        csr_ready,
   input  wire logic [13:0] csr_data,     // block_count
   input  wire logic        req_tvalid,
   output wire logic        req_tready,
   input  wire logic [15:0] req_tdata,    // [13:0] block_number, [15:14] zero
   input  wire logic [0:0]  req_tuser,    // [0] command
   output wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output wire logic [31:0] rsp_tdata     // [13:0] allocated_block, [15:14] status,
                                          // [29:16] free_count, [31:30] zero
);
   import bba_pkg::*;

   `include "bitmap_block_allocator_macros.svh"

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SRCH = 2'd1;
   localparam logic [1:0] S_READ = 2'd2;
   localparam logic [1:0] S_MOD  = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [CNT_W-1:0]     block_count_ff;
   logic [CNT_W-1:0]     used_count_ff, used_count_in;
   logic [MAP_WORDS-1:0] valid_ff, valid_in;
   logic [MAP_WORDS-1:0] full_ff, full_in;
   logic                 cmd_ff, cmd_in;
   logic [IDX_W-1:0]     addr_ff, addr_in;
   logic                 skip_ff, skip_in;
   logic [1:0]           stat_ff, stat_in;
   logic [WORD_AW-1:0]   word_ff, word_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]     rsp_alloc_ff, rsp_alloc_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]     rsp_free_ff, rsp_free_in;

   logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
   logic [WORD_BITS-1:0] rdata_ff;
   logic                 rvalid_ff;
   logic                 mem_re;
   logic [WORD_AW-1:0]   mem_raddr;
   logic                 mem_we;
   logic [WORD_BITS-1:0] mem_wdata;

   logic [CNT_W-1:0]     eff_count;
   logic                 req_fire;
   logic [CNT_W-1:0]     bno;
   logic                 bad_bno;
   logic [WORD_BITS-1:0] cur_word;
   logic [BIT_AW-1:0]    zero_bit;
   logic                 zero_ok;
   logic [IDX_W-1:0]     alloc_idx;
   logic                 alloc_ok;
   logic                 mod_fire;
   search_result_type    srch;

   bba_search u_search (
      .clock    (clock),
      .full_map (full_ff),
      .result   (srch)
   );

   assign eff_count = (block_count_ff > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                             : block_count_ff;
   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign bno        = req_tdata[CNT_W-1:0];
   assign bad_bno    = (bno == '0) || (bno > eff_count);
   assign mod_fire   = (state_ff == S_MOD) && (!rsp_valid_ff || rsp_tready);

   // A word that was never written since reset reads as all free.
   assign cur_word = rvalid_ff ? rdata_ff : '0;

   always_comb begin
      zero_bit = '0;
      zero_ok  = 1'b0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (!cur_word[b]) begin
            zero_bit = BIT_AW'(b);
            zero_ok  = 1'b1;
         end
      end
   end

   assign alloc_idx = {word_ff, zero_bit};
   assign alloc_ok  = zero_ok && ({1'b0, alloc_idx} < eff_count);

   always_comb begin
      state_in      = state_ff;
      used_count_in = used_count_ff;
      valid_in      = valid_ff;
      full_in       = full_ff;
      cmd_in        = cmd_ff;
      addr_in       = addr_ff;
      skip_in       = skip_ff;
      stat_in       = stat_ff;
      word_in       = word_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_alloc_in  = rsp_alloc_ff;
      rsp_status_in = rsp_status_ff;
      rsp_free_in   = rsp_free_ff;
      mem_re        = 1'b0;
      mem_raddr     = (cmd_ff == CMD_ALLOC) ? srch.word : addr_ff[IDX_W-1:BIT_AW];
      mem_we        = 1'b0;
      mem_wdata     = cur_word;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd_in   = req_tuser[0];
               addr_in  = IDX_W'(bno - CNT_W'(1));
               skip_in  = (req_tuser[0] == CMD_FREE) && bad_bno;
               stat_in  = STATUS_BAD_BLOCK;
               state_in = (req_tuser[0] == CMD_ALLOC) ? S_SRCH : S_READ;
            end
         end
         S_SRCH: begin
            state_in = S_READ;
         end
         S_READ: begin
            mem_re  = 1'b1;
            word_in = mem_raddr;
            if (cmd_ff == CMD_ALLOC && !srch.found) begin
               skip_in = 1'b1;
               stat_in = STATUS_NO_FREE;
            end
            state_in = S_MOD;
         end
         S_MOD: begin
            if (mod_fire) begin
               rsp_alloc_in  = '0;
               rsp_status_in = STATUS_OK;
               if (skip_ff) begin
                  rsp_status_in = stat_ff;
               end else if (cmd_ff == CMD_ALLOC) begin
                  if (alloc_ok) begin
                     mem_we        = 1'b1;
                     mem_wdata     = cur_word | (WORD_BITS'(1) << zero_bit);
                     used_count_in = used_count_ff + CNT_W'(1);
                     rsp_alloc_in  = {1'b0, alloc_idx} + CNT_W'(1);
                  end else begin
                     rsp_status_in = STATUS_NO_FREE;
                  end
               end else begin
                  if (cur_word[addr_ff[BIT_AW-1:0]]) begin
                     mem_we    = 1'b1;
                     mem_wdata = cur_word & ~(WORD_BITS'(1) << addr_ff[BIT_AW-1:0]);
                     if (used_count_ff != '0) begin
                        used_count_in = used_count_ff - CNT_W'(1);
                     end
                  end
               end
               if (mem_we) begin
                  valid_in[word_ff] = 1'b1;
                  full_in[word_ff]  = &mem_wdata;
               end
               rsp_free_in  = (used_count_in >= eff_count) ? '0
                                                           : eff_count - used_count_in;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         used_count_ff  <= '0;
         valid_ff       <= '0;
         full_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
         block_count_ff <= CNT_W'(MAX_BLOCKS);
      end else begin
         state_ff      <= state_in;
         used_count_ff <= used_count_in;
         valid_ff      <= valid_in;
         full_ff       <= full_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            block_count_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      addr_ff       <= addr_in;
      skip_ff       <= skip_in;
      stat_ff       <= stat_in;
      word_ff       <= word_in;
      rsp_alloc_ff  <= rsp_alloc_in;
      rsp_status_ff <= rsp_status_in;
      rsp_free_ff   <= rsp_free_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[word_ff] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff  <= map_mem[mem_raddr];
         rvalid_ff <= valid_ff[mem_raddr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_free_ff, rsp_status_ff, rsp_alloc_ff};

   `BBA_ASSERT_NEVER(a_count_range, clock, reset, used_count_ff > CNT_W'(MAX_BLOCKS))
   `BBA_ASSERT_IMPLIES(a_alloc_ok, clock, reset,
      rsp_valid_ff && rsp_alloc_ff != '0, rsp_status_ff == STATUS_OK)
   `BBA_ASSERT_IMPLIES(a_count_step, clock, reset,
      !$past(reset) && used_count_ff != $past(used_count_ff), $past(state_ff) == S_MOD)
   `BBA_ASSERT_IMPLIES(a_write_in_mod, clock, reset, mem_we, state_ff == S_MOD && !skip_ff)

endmodule

`default_nettype wire

// ===== hw/rtl/bba_search.sv =====
// Two-stage search for the lowest map word that still has a free bit.
// Depends on bba_pkg; works from the per-word full flags kept by the top level.
`timescale 1ns / 1ps
`default_nettype none

module bba_search (
   input  wire logic                                   clock,
   input  wire logic [bba_pkg::MAP_WORDS-1:0]          full_map,
   output bba_pkg::search_result_type                  result
);
   import bba_pkg::*;

   logic [GSEL_AW-1:0]    group_in;
   logic                  group_ok_in;
   logic [GSEL_AW-1:0]    group_ff;
   logic                  group_ok_ff;
   logic [GROUP_SIZE-1:0] slice;
   logic [GROUP_AW-1:0]   word_in;
   logic                  word_ok_in;
   search_result_type     result_ff;

   // First stage: lowest group of words that holds a word which is not full.
   always_comb begin
      group_in    = '0;
      group_ok_in = 1'b0;
      for (int g = GROUPS - 1; g >= 0; g--) begin
         if (!(&full_map[g*GROUP_SIZE +: GROUP_SIZE])) begin
            group_in    = GSEL_AW'(g);
            group_ok_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      group_ff    <= group_in;
      group_ok_ff <= group_ok_in;
   end

   // Second stage: lowest word inside the chosen group.
   always_comb begin
      slice      = full_map[group_ff*GROUP_SIZE +: GROUP_SIZE];
      word_in    = '0;
      word_ok_in = 1'b0;
      for (int w = GROUP_SIZE - 1; w >= 0; w--) begin
         if (!slice[w]) begin
            word_in    = GROUP_AW'(w);
            word_ok_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      result_ff.found <= group_ok_ff & word_ok_in;
      result_ff.word  <= {group_ff, word_in};
   end

   assign result = result_ff;

endmodule

`default_nettype wire

// ===== dv/tb_bitmap_block_allocator.sv =====
// Self-checking testbench for the first-fit bitmap block allocator.
// Predicts every result from its own copy of the used map and count; needs bba_pkg
// and the bitmap_block_allocator RTL.
`timescale 1ns / 1ps

module tb_bitmap_block_allocator;
   import bba_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned DRAIN_CYCLES = 8;

   typedef struct {
      logic [CNT_W-1:0] block;
      logic [1:0]       status;
      logic [CNT_W-1:0] free_left;
   } alloc_outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [13:0] csr_data = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [15:0] req_tdata = '0;  // [13:0] block_number, [15:14] zero
   logic [0:0] req_tuser = '0;   // [0] command
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;       // [13:0] allocated_block, [15:14] status,
                                 // [29:16] free_count, [31:30] zero

   // Predictor state.
   bit used_map [MAX_BLOCKS];
   int unsigned used_total = 0;
   logic [CNT_W-1:0] block_limit = 14'd8192;

   alloc_outcome_type pending_outcomes[$];
   int unsigned err_count = 0;
   bit idle_on = 1'b1;
   bit rsp_hold_req = 1'b0;
   bit req_held = 1'b0;

   bitmap_block_allocator u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic int unsigned managed_blocks();
      return (block_limit > MAX_BLOCKS) ? MAX_BLOCKS : block_limit;
   endfunction

   function automatic alloc_outcome_type apply_command(input logic cmd,
                                                       input logic [CNT_W-1:0] bno);
      alloc_outcome_type o;
      int unsigned n;
      n = managed_blocks();
      o.block = '0;
      o.status = STATUS_OK;
      if (cmd == CMD_ALLOC) begin
         o.status = STATUS_NO_FREE;
         for (int unsigned i = 0; i < n; i++) begin
            if (!used_map[i]) begin
               used_map[i] = 1'b1;
               used_total++;
               o.block = CNT_W'(i + 1);
               o.status = STATUS_OK;
               break;
            end
         end
      end else if (bno == 0 || bno > n) begin
         o.status = STATUS_BAD_BLOCK;
      end else if (used_map[bno - 1]) begin
         used_map[bno - 1] = 1'b0;
         if (used_total > 0) used_total--;
      end
      o.free_left = (used_total >= n) ? '0 : CNT_W'(n - used_total);
      return o;
   endfunction

   // Mostly valid block numbers, some right at the edges, some anywhere in the field.
   function automatic logic [CNT_W-1:0] pick_free_target();
      int unsigned n;
      int unsigned r;
      n = managed_blocks();
      r = $urandom_range(0, 99);
      if (r < 70 && n > 0) return CNT_W'($urandom_range(1, n));
      if (r < 85) begin
         case ($urandom_range(0, 2))
            0: return '0;
            1: return CNT_W'(n);
            default: return CNT_W'(n + 1);
         endcase
      end
      return CNT_W'($urandom_range(0, 16383));
   endfunction

   // Called just after a rising edge; returns at the edge where the item was taken.
   task automatic send_op(input logic cmd, input logic [CNT_W-1:0] bno);
      int unsigned gap;
      gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         req_held = 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, bno};
      req_tuser <= cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      req_held = 1'b1;
      pending_outcomes.push_back(apply_command(cmd, bno));
   endtask

   task automatic wait_drained();
      if (req_held) begin
         req_tvalid <= 1'b0;
         req_held = 1'b0;
      end
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic write_block_count(input logic [CNT_W-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      block_limit = value;
      csr_valid <= 1'b0;
   endtask

   task automatic run_random(input int unsigned items, input int unsigned alloc_pct);
      logic cmd;
      for (int unsigned k = 0; k < items; k++) begin
         cmd = ($urandom_range(0, 99) < alloc_pct) ? CMD_ALLOC : CMD_FREE;
         if (cmd == CMD_ALLOC) send_op(cmd, CNT_W'($urandom_range(0, 16383)));
         else send_op(cmd, pick_free_target());
      end
   endtask

   task automatic test_directed_edges();
      // Reset count of 8192: first-fit order and reuse of a freed hole.
      repeat (3) send_op(CMD_ALLOC, CNT_W'($urandom_range(0, 16383)));
      send_op(CMD_FREE, 14'd2);
      send_op(CMD_ALLOC, 14'd16383);
      send_op(CMD_FREE, 14'd0);
      send_op(CMD_FREE, 14'd8193);
      send_op(CMD_FREE, 14'd16383);
      send_op(CMD_FREE, 14'd8192);
      send_op(CMD_FREE, 14'd5);
      // No blocks managed at all.
      write_block_count(14'd0);
      send_op(CMD_ALLOC, 14'd0);
      send_op(CMD_FREE, 14'd1);
      // A count above the map size saturates.
      write_block_count(14'd16383);
      send_op(CMD_FREE, 14'd8192);
      send_op(CMD_FREE, 14'd8193);
      send_op(CMD_ALLOC, 14'd0);
      // Shrink below the used blocks: free count reads zero until enough are freed.
      write_block_count(14'd2);
      send_op(CMD_ALLOC, 14'd0);
      send_op(CMD_FREE, 14'd3);
      send_op(CMD_FREE, 14'd1);
      send_op(CMD_FREE, 14'd2);
      write_block_count(14'd1);
      send_op(CMD_ALLOC, 14'd0);
      send_op(CMD_ALLOC, 14'd0);
   endtask

   task automatic test_small_pools();
      write_block_count(14'd1);
      run_random(60, 50);
      write_block_count(14'd8);
      run_random(150, 65);
      write_block_count(CNT_W'($urandom_range(2, 64)));
      run_random(250, 55);
   endtask

   task automatic test_large_pools();
      write_block_count(14'd8192);
      run_random(200, 70);
      write_block_count(14'd16383);
      run_random(100, 50);
      write_block_count(14'd0);
      run_random(40, 50);
   endtask

   task automatic test_shrink_below_used();
      write_block_count(14'd40);
      run_random(60, 90);
      write_block_count(14'd10);
      run_random(100, 40);
   endtask

   task automatic test_backpressure();
      write_block_count(14'd32);
      // The receiver stalls on its own while items keep coming.
      rsp_hold_req = 1'b1;
      run_random(30, 70);
      wait_drained();
      run_random(30, 50);
   endtask

   task automatic test_final_burst();
      idle_on = 1'b0;
      write_block_count(CNT_W'($urandom_range(1, 200)));
      run_random(200, 60);
   endtask

   // Receiver: random stall bursts, free-running stretches, and one long hold-off.
   initial begin
      @(negedge reset);
      forever begin
         if (rsp_hold_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold_req = 1'b0;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      alloc_outcome_type exp_o;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_outcomes.size() == 0) begin
            $error("unexpected result item: data 0x%08h", rsp_tdata);
            err_count++;
         end else begin
            exp_o = pending_outcomes.pop_front();
            if (rsp_tdata[13:0] !== exp_o.block) begin
               $error("allocated_block mismatch: expected %0d, actual %0d",
                      exp_o.block, rsp_tdata[13:0]);
               err_count++;
            end
            if (rsp_tdata[15:14] !== exp_o.status) begin
               $error("status mismatch: expected %0d, actual %0d",
                      exp_o.status, rsp_tdata[15:14]);
               err_count++;
            end
            if (rsp_tdata[29:16] !== exp_o.free_left) begin
               $error("free_count mismatch: expected %0d, actual %0d",
                      exp_o.free_left, rsp_tdata[29:16]);
               err_count++;
            end
         end
      end
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed_edges();
      test_small_pools();
      test_large_pools();
      test_shrink_below_used();
      test_backpressure();
      test_final_burst();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_outcomes.size() != 0) begin
         $error("%0d results never arrived", pending_outcomes.size());
         err_count++;
      end
      if (err_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
